/* rtl/lcfe_pkg.sv */
// ----------------------------------------------------------------------------
// LED channel fade engine package
// Shared constants, codes and types of the fade engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfe_pkg;

  localparam int unsigned CHANNELS = 32;
  localparam int unsigned CH_W     = $clog2(CHANNELS);
  localparam int unsigned DVD_W    = 16;
  localparam int unsigned DVS_W    = 17;
  localparam int unsigned CNT_W    = $clog2(DVD_W);

  typedef enum logic [1:0] {
    FUNC_SET  = 2'd0,
    FUNC_FADE = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_CALC,
    ST_F_DIV1,
    ST_F_DIV2,
    ST_F_DIV3,
    ST_T_RD,
    ST_T_CHK,
    ST_T_DIV,
    ST_E_RD,
    ST_E_LD
  } state_e;

  typedef struct packed {
    logic [7:0]        level;
    logic signed [8:0] step;
    logic [16:0]       period;
    logic [7:0]        left;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/lcfe_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/lcfe_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider that resolves one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_div
  import lcfe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quot_o,
  output logic      [DVS_W-1:0] rem_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] r_q, r_d, dvs_q, dvs_d;
  logic [DVD_W-1:0] q_q, q_d;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial  = {r_q, q_q[DVD_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    q_d    = q_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      r_d   = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      q_d   = {q_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      q_d    = dividend_i;
      dvs_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    q_q   <= q_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

/* rtl/led_channel_fade_engine.sv */
// ----------------------------------------------------------------------------
// LED channel fade engine
// Holds per-channel levels and fades, advances them on ticks, reports frames.
//
// Items enter on the in channel and results leave on the out channel, both
// with valid and ready. A set item writes a level in the cycle it is taken.
// A fade item reads the channel entry and runs none, one or two divisions
// on the shared divider. A tick item walks every channel: a fading channel
// gets a period check in the divider, an idle one only a read of its entry.
// The frame is then read back from the entry memory, one result per channel,
// while the receiver takes them. A stall on the out side holds the frame
// walk; the last result may still wait while the next item is taken. Reset
// clears the tick counter and marks every entry as unwritten, so it reads
// as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module led_channel_fade_engine
  import lcfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [5:0]  channel_i,
  input  wire logic [7:0]  intensity_i,
  input  wire logic [15:0] duration_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [5:0]  out_channel_o,
  output logic      [7:0]  level_o,
  output logic             frame_changed_o,
  output logic             last_o
);

  state_e              state_q, state_d;
  logic [CH_W-1:0]     idx_q, idx_d;
  logic [14:0]         tick_q, tick_d;
  logic                chg_q, chg_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic                rd_vld_q;
  logic                out_valid_q, out_valid_d;
  logic [5:0]          out_ch_q, out_ch_d;
  logic [7:0]          out_lvl_q, out_lvl_d;
  logic                out_chg_q, out_chg_d;
  logic                out_last_q, out_last_d;
  logic [7:0]          tgt_q, tgt_d, mag_q, mag_d, smag_q, smag_d;
  logic [15:0]         dur_q, dur_d;
  logic                neg_q, neg_d;
  entry_t              ent_q, ent_d;

  logic                we, re;
  logic [CH_W-1:0]     waddr, raddr;
  entry_t              wdata, rd_ent;
  logic [ENTRY_W-1:0]  rdata;

  logic                div_start, div_busy, div_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [DVS_W-1:0]    div_dvs, div_r;

  logic                in_acc, ch_ok, is_last;
  logic [15:0]         dur_eff;
  logic signed [9:0]   sim;
  logic [7:0]          new_lvl, new_left;

  lcfe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lcfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  assign rd_ent  = rd_vld_q ? entry_t'(rdata) : '0;
  assign in_acc  = in_valid_i && in_ready_o;
  assign ch_ok   = {1'b0, channel_i} < 7'(CHANNELS);
  assign is_last = idx_q == CH_W'(CHANNELS - 1);
  assign dur_eff = (dur_q == 16'd0) ? 16'd1 : dur_q;

  always_comb begin
    sim      = 10'(signed'({2'b00, ent_q.level})) + 10'(ent_q.step);
    new_lvl  = sim[7:0];
    new_left = ent_q.left - 8'd1;
    if (sim > 10'sd255) begin
      new_lvl  = 8'd255;
      new_left = 8'd0;
    end else if (sim < 10'sd0) begin
      new_lvl  = 8'd0;
      new_left = 8'd0;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tick_d      = tick_q;
    chg_d       = chg_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ch_d    = out_ch_q;
    out_lvl_d   = out_lvl_q;
    out_chg_d   = out_chg_q;
    out_last_d  = out_last_q;
    tgt_d       = tgt_q;
    mag_d       = mag_q;
    smag_d      = smag_q;
    dur_d       = dur_q;
    neg_d       = neg_q;
    ent_d       = ent_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_q;
    raddr       = idx_q;
    wdata       = ent_q;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          idx_d = channel_i[CH_W-1:0];
          tgt_d = intensity_i;
          dur_d = duration_i;
          case (func_i)
            FUNC_SET: begin
              if (ch_ok) begin
                we           = 1'b1;
                waddr        = channel_i[CH_W-1:0];
                wdata        = '0;
                wdata.level  = intensity_i;
                vld_d[waddr] = 1'b1;
              end
            end
            FUNC_FADE: begin
              if (ch_ok) begin
                re      = 1'b1;
                raddr   = channel_i[CH_W-1:0];
                state_d = ST_F_CALC;
              end
            end
            FUNC_TICK: begin
              tick_d  = tick_q + 15'd1;
              chg_d   = 1'b0;
              idx_d   = '0;
              state_d = ST_T_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_F_CALC: begin
        ent_d = rd_ent;
        neg_d = tgt_q < rd_ent.level;
        mag_d = neg_d ? rd_ent.level - tgt_q : tgt_q - rd_ent.level;
        if (mag_d == 8'd0) begin
          state_d = ST_IDLE;
        end else if (dur_eff < {8'd0, mag_d}) begin
          div_start = 1'b1;
          div_dvd   = {8'd0, mag_d};
          div_dvs   = {1'b0, dur_eff};
          state_d   = ST_F_DIV1;
        end else begin
          div_start = 1'b1;
          div_dvd   = dur_eff;
          div_dvs   = {9'd0, mag_d};
          state_d   = ST_F_DIV3;
        end
      end
      ST_F_DIV1: begin
        if (div_done) begin
          smag_d    = div_q[7:0];
          div_start = 1'b1;
          div_dvd   = {8'd0, mag_q};
          div_dvs   = {9'd0, div_q[7:0]};
          state_d   = ST_F_DIV2;
        end
      end
      ST_F_DIV2: begin
        if (div_done) begin
          we           = 1'b1;
          wdata.level  = ent_q.level;
          wdata.step   = neg_q ? -signed'({1'b0, smag_q}) : signed'({1'b0, smag_q});
          wdata.period = 17'd1;
          wdata.left   = div_q[7:0];
          vld_d[waddr] = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_F_DIV3: begin
        if (div_done) begin
          we           = 1'b1;
          wdata.level  = ent_q.level;
          wdata.step   = neg_q ? -9'sd1 : 9'sd1;
          wdata.period = {1'b0, div_q} + 17'd1;
          wdata.left   = mag_q;
          vld_d[waddr] = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_T_RD: begin
        re      = 1'b1;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        ent_d = rd_ent;
        if (rd_ent.period != 17'd0) begin
          div_start = 1'b1;
          div_dvd   = {1'b0, tick_q};
          div_dvs   = rd_ent.period;
          state_d   = ST_T_DIV;
        end else if (is_last) begin
          idx_d   = '0;
          state_d = ST_E_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_T_RD;
        end
      end
      ST_T_DIV: begin
        if (div_done) begin
          if (div_r == '0) begin
            we           = 1'b1;
            wdata.level  = new_lvl;
            wdata.left   = new_left;
            wdata.period = (new_left == 8'd0) ? 17'd0 : ent_q.period;
            vld_d[waddr] = 1'b1;
            if (new_lvl != ent_q.level) begin
              chg_d = 1'b1;
            end
          end
          if (is_last) begin
            idx_d   = '0;
            state_d = ST_E_RD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_T_RD;
          end
        end
      end
      ST_E_RD: begin
        re      = 1'b1;
        state_d = ST_E_LD;
      end
      ST_E_LD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ch_d    = 6'(idx_q);
          out_lvl_d   = rd_ent.level;
          out_chg_d   = chg_q;
          out_last_d  = is_last;
          if (is_last) begin
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_E_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      tick_q      <= '0;
      chg_q       <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      tick_q      <= tick_d;
      chg_q       <= chg_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      if (re) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_ch_q   <= out_ch_d;
    out_lvl_q  <= out_lvl_d;
    out_chg_q  <= out_chg_d;
    out_last_q <= out_last_d;
    tgt_q      <= tgt_d;
    mag_q      <= mag_d;
    smag_q     <= smag_d;
    dur_q      <= dur_d;
    neg_q      <= neg_d;
    ent_q      <= ent_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_ch_q;
  assign level_o         = out_lvl_q;
  assign frame_changed_o = out_chg_q;
  assign last_o          = out_last_q;

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_F_DIV1 || state_q == ST_F_DIV2 ||
                  state_q == ST_F_DIV3 || state_q == ST_T_DIV))
    else $error("divider finished outside a division state");

  a_idle_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_no_write_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !(state_q == ST_E_RD || state_q == ST_E_LD))
    else $error("entry write during frame readout");

  a_tick_only_on_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && func_i == FUNC_TICK) |=> $stable(tick_q))
    else $error("tick counter moved without a tick transfer");

endmodule

`default_nettype wire
